### sv/adcss_pkg.sv
// ----------------------------------------------------------------------------
// adcss_pkg
// Shared types, constants and decode functions for the ADC value
// seven-segment scanner.
// ----------------------------------------------------------------------------
package adcss_pkg;

   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int SAMPLE_W           = 10;
   localparam int DIGIT_W            = 4;
   localparam int MODE_W             = 2;
   localparam int CSR_W              = 10;
   localparam int SEL_W              = 4;
   localparam int SEG_W              = 8;
   localparam int BASE_DIGITS        = 4;

   localparam logic [SAMPLE_W-1:0] TEMP_OFFSET_RESET = 10'd342;
   localparam logic [MODE_W-1:0]   MODE_RAW_RESET    = 2'd0;
   localparam logic [MODE_W-1:0]   MODE_TEMP         = 2'd3;
   localparam logic [DIGIT_W-1:0]  DIGIT_RESET       = 4'd8;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic {
      CSR_DISPLAY_MODE = 1'b0,
      CSR_TEMP_OFFSET  = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type              opcode;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic [SEL_W-1:0] digit_select_n;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic [SAMPLE_W-1:0] value;
   } digit_wr_type;

   typedef struct packed {
      logic busy;
   } scan_status_type;

   // Decimal position counted from the least significant digit.
   function automatic logic [DIGIT_W-1:0] reset_digit(input int pos);
      reset_digit = (pos < BASE_DIGITS) ? DIGIT_RESET : '0;
   endfunction

   // Exact quotient by ten for any 10-bit value.
   function automatic logic [SAMPLE_W-1:0] div10(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W+8-1:0] prod;
      prod  = {8'd0, v} * 18'd205;
      div10 = prod[SAMPLE_W+8-1:11];
   endfunction

   function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
      case (d)
         4'd0:    seg_decode = 8'h3F;
         4'd1:    seg_decode = 8'h06;
         4'd2:    seg_decode = 8'h5B;
         4'd3:    seg_decode = 8'h4F;
         4'd4:    seg_decode = 8'h66;
         4'd5:    seg_decode = 8'h6D;
         4'd6:    seg_decode = 8'h7D;
         4'd7:    seg_decode = 8'h07;
         4'd8:    seg_decode = 8'h7F;
         4'd9:    seg_decode = 8'h6F;
         default: seg_decode = SEG_BLANK;
      endcase
   endfunction

endpackage

### sv/adcss_digits.sv
// ----------------------------------------------------------------------------
// adcss_digits
// Splits the shown value into decimal digits and holds them in the digit
// store, most significant digit at index 0.
// ----------------------------------------------------------------------------
module adcss_digits #(
   parameter int NUM_DIGITS = adcss_pkg::NUM_DIGITS_DEFAULT,
   parameter int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  adcss_pkg::digit_wr_type       wr,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [adcss_pkg::DIGIT_W-1:0] rd_digit
);
   import adcss_pkg::*;

   logic [DIGIT_W-1:0]  digits_ff [NUM_DIGITS];
   logic [DIGIT_W-1:0]  digits_in [NUM_DIGITS];
   logic [DIGIT_W-1:0]  lsb_digit [BASE_DIGITS];
   logic [SAMPLE_W-1:0] rest      [BASE_DIGITS+1];
   logic [SAMPLE_W-1:0] quot      [BASE_DIGITS];

   always_comb begin
      rest[0] = wr.value;
      for (int p = 0; p < BASE_DIGITS; p++) begin
         quot[p]      = div10(rest[p]);
         lsb_digit[p] = DIGIT_W'(rest[p] - ({quot[p][SAMPLE_W-4:0], 3'b000}
                                          + {quot[p][SAMPLE_W-2:0], 1'b0}));
         rest[p+1]    = quot[p];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if ((NUM_DIGITS - 1 - i) < BASE_DIGITS) begin
            digits_in[i] = lsb_digit[NUM_DIGITS - 1 - i];
         end else begin
            digits_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= reset_digit(NUM_DIGITS - 1 - i);
         end
      end else if (wr.load) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
      end
   end

   assign rd_digit = digits_ff[rd_idx];

endmodule

### sv/adcss_scan.sv
// ----------------------------------------------------------------------------
// adcss_scan
// Scan index, segment and select decode, and the result register.
// ----------------------------------------------------------------------------
module adcss_scan #(
   parameter int NUM_DIGITS = adcss_pkg::NUM_DIGITS_DEFAULT,
   parameter int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick_go,
   input  logic [adcss_pkg::DIGIT_W-1:0] digit,
   output logic [IDX_W-1:0]              idx,
   output adcss_pkg::scan_status_type    status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output adcss_pkg::rsp_type            rsp_data
);
   import adcss_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   always_comb begin
      idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   end

   always_comb begin
      rsp_data_in.segments       = seg_decode(digit);
      rsp_data_in.digit_select_n = '1;
      for (int j = 0; j < SEL_W; j++) begin
         if (j < NUM_DIGITS) begin
            if (idx_ff == IDX_W'(j)) begin
               rsp_data_in.digit_select_n[j] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (tick_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (tick_go) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign idx         = idx_ff;
   assign status.busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

endmodule

### sv/adc_value_seven_segment_scanner_core.sv
// ----------------------------------------------------------------------------
// adc_value_seven_segment_scanner_core
// Multiplexed seven-segment driver for a 10-bit ADC value: samples update
// the stored digits, scan ticks return one segment byte and select mask.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  opcode, sample
//   rsp_      out        rsp_valid / rsp_stall  segments, digit_select_n
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// One item per cycle unless req_stall is high. An item waits in the input register;
// a scan tick moves on to the result register once the result is not stalled.
// A sample writes the digit store from the input register and gives no result.
// Reset (synchronous) restores the low four digits to 8, others and the scan index to 0.
// A stalled result holds the input register only when it holds a scan tick.
// ----------------------------------------------------------------------------
module adc_value_seven_segment_scanner_core #(
   parameter int NUM_DIGITS = adcss_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  adcss_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output adcss_pkg::rsp_type           rsp_data,
   input  logic                         csr_we,
   input  adcss_pkg::csr_index_type     csr_index,
   input  logic [adcss_pkg::CSR_W-1:0]  csr_wdata
);
   import adcss_pkg::*;

   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic                stage_valid_ff;
   logic                stage_valid_in;
   req_type             stage_ff;
   logic [MODE_W-1:0]   display_mode_ff;
   logic [SAMPLE_W-1:0] temp_offset_ff;
   logic                accept;
   logic                stage_block;
   logic                tick_go;
   digit_wr_type        wr;
   scan_status_type     status;
   logic [IDX_W-1:0]    rd_idx;
   logic [DIGIT_W-1:0]  rd_digit;

   assign stage_block = stage_valid_ff && (stage_ff.opcode == OP_TICK) && status.busy;
   assign req_stall   = stage_block;
   assign accept      = req_valid && !req_stall;
   assign tick_go     = stage_valid_ff && (stage_ff.opcode == OP_TICK) && !status.busy;

   always_comb begin
      stage_valid_in = accept || stage_block;
   end

   always_comb begin
      wr.load = stage_valid_ff && (stage_ff.opcode == OP_SAMPLE);
      if (display_mode_ff != MODE_TEMP) begin
         wr.value = stage_ff.sample;
      end else if (stage_ff.sample >= temp_offset_ff) begin
         wr.value = stage_ff.sample - temp_offset_ff;
      end else begin
         wr.value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         display_mode_ff <= MODE_RAW_RESET;
         temp_offset_ff  <= TEMP_OFFSET_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DISPLAY_MODE: display_mode_ff <= csr_wdata[MODE_W-1:0];
               CSR_TEMP_OFFSET:  temp_offset_ff  <= csr_wdata[SAMPLE_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_data;
      end
   end

   adcss_digits #(
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_W      (IDX_W)
   ) u_digits (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_digit (rd_digit)
   );

   adcss_scan #(
      .NUM_DIGITS (NUM_DIGITS),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .tick_go   (tick_go),
      .digit     (rd_digit),
      .idx       (rd_idx),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/adcss_checker.sv
// ----------------------------------------------------------------------------
// adcss_checker
// Port-level checks for the ADC value seven-segment scanner.
// ----------------------------------------------------------------------------
module adcss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input adcss_pkg::req_type           req_data,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input adcss_pkg::rsp_type           rsp_data,
   input logic                         csr_we,
   input adcss_pkg::csr_index_type     csr_index,
   input logic [adcss_pkg::CSR_W-1:0]  csr_wdata
);
   import adcss_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_dot_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.segments[SEG_W-1] == 1'b0)
      else $error("decimal point lit");

   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_data.digit_select_n) <= 1)
      else $error("more than one digit selected");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

endmodule

bind adc_value_seven_segment_scanner_core adcss_checker u_adcss_checker (.*);
